[src/resyncing_radio_frame_deframer_macros.svh]
// Assertion helpers for the deframer; clock and reset are taken from the
// enclosing module (clk, rst).
`ifndef RESYNCING_RADIO_FRAME_DEFRAMER_MACROS_SVH
`define RESYNCING_RADIO_FRAME_DEFRAMER_MACROS_SVH

// Property holds in the same cycle as its antecedent
`define RRFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Property holds in the cycle after its antecedent
`define RRFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rrfd_pkg.sv]
package rrfd_pkg;

  // Default width of the payload length and countdown
  localparam int LEN_BITS_DEF = 15;

  // Fixed field widths
  localparam int BYTE_W      = 8;
  localparam int KEY_W       = 16;
  localparam int SENDER_W    = 32;
  localparam int FRAME_LEN_W = 15;
  localparam int WINDOW_W    = 64;
  localparam int WINDOW_N    = 8;
  localparam int FILL_W      = 4;

  // Output tdata: payload byte, sender address, frame length, zero pad
  localparam int OUT_DATA_W  = 56;

endpackage

[src/resyncing_radio_frame_deframer.sv]
// Byte-stream deframer with resynchronisation. Received bytes enter on the
// s_ side one per transaction; while hunting, an 8-byte window is searched
// for a header (size, check, sender address, all little endian) whose size
// equals check XOR size_key and is a positive length below 2**LEN_BITS.
// Leading zero bytes are skipped and a failed test slides the window by one
// byte. After a header the next size bytes leave on the m_ side tagged with
// sender address, length, first (tuser) and last (tlast) marks; header bytes
// produce no output. One byte is accepted every cycle while the m_ side does
// not stall: each byte is handled by one registered update of the hunt/countdown
// state, and an output register still takes a new byte when the held result
// is taken in the same cycle.
`include "resyncing_radio_frame_deframer_macros.svh"

module resyncing_radio_frame_deframer
  import rrfd_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [KEY_W-1:0]      cfg_wdata,    // size_key
  // received bytes
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,      // in_byte
  // payload bytes
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,      // payload_byte[7:0], sender_ip[39:8],
                                              // frame_length[54:40], zero[55]
  output logic                  m_tuser,      // first_of_frame
  output logic                  m_tlast       // last_of_frame
);

  // State
  logic [KEY_W-1:0]    size_key;
  logic [WINDOW_W-1:0] header_window, header_window_next;
  logic [FILL_W-1:0]   window_fill, window_fill_next;
  logic                in_payload, in_payload_next;
  logic [LEN_BITS-1:0] bytes_remaining, bytes_remaining_next;
  logic [LEN_BITS-1:0] held_length, held_length_next;
  logic [SENDER_W-1:0] held_sender, held_sender_next;

  // Hunt datapath
  logic                s_fire;
  logic                m_fire;
  logic [WINDOW_W-1:0] win_add;
  logic [FILL_W-1:0]   fill_add;
  logic [FILL_W-1:0]   zero_skip;
  logic                found_nz;
  logic [6:0]          skip_shift;
  logic [WINDOW_W-1:0] win_nz;
  logic [FILL_W-1:0]   fill_nz;
  logic [KEY_W-1:0]    hdr_size;
  logic [KEY_W-1:0]    hdr_check;
  logic                hdr_ok;
  logic                last_byte;

  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = m_tvalid && m_tready;
  assign s_tready = !m_tvalid || m_tready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_key <= '0;
    end else if (cfg_we) begin
      size_key <= cfg_wdata;
    end
  end

  // Append the new byte at the fill position (fill is below eight while hunting)
  always_comb begin
    win_add = header_window;
    for (int i = 0; i < WINDOW_N; i++) begin
      if (window_fill[2:0] == 3'(i)) begin
        win_add[i*BYTE_W +: BYTE_W] = s_tdata;
      end
    end
    fill_add = window_fill + FILL_W'(1);
  end

  // Count leading zero bytes of the filled part; bytes above fill are zero
  always_comb begin
    zero_skip = fill_add;
    found_nz  = 1'b0;
    for (int i = 0; i < WINDOW_N; i++) begin
      if (!found_nz && (FILL_W'(i) < fill_add) &&
          (win_add[i*BYTE_W +: BYTE_W] != '0)) begin
        zero_skip = FILL_W'(i);
        found_nz  = 1'b1;
      end
    end
    skip_shift = {zero_skip[3:0], 3'b000};
    win_nz     = win_add >> skip_shift;
    fill_nz    = fill_add - zero_skip;
  end

  // Header test on a full window
  assign hdr_size  = win_nz[15:0];
  assign hdr_check = win_nz[31:16];
  assign hdr_ok    = (hdr_size == (hdr_check ^ size_key)) && (hdr_size != '0) &&
                     !hdr_size[15] && ((hdr_size >> LEN_BITS) == '0);

  assign last_byte = (bytes_remaining <= LEN_BITS'(1));

  // Next state
  always_comb begin
    header_window_next   = header_window;
    window_fill_next     = window_fill;
    in_payload_next      = in_payload;
    bytes_remaining_next = bytes_remaining;
    held_length_next     = held_length;
    held_sender_next     = held_sender;
    if (in_payload) begin
      if (last_byte) begin
        in_payload_next      = 1'b0;
        bytes_remaining_next = '0;
        header_window_next   = '0;
        window_fill_next     = '0;
      end else begin
        bytes_remaining_next = bytes_remaining - LEN_BITS'(1);
      end
    end else if (fill_nz == FILL_W'(WINDOW_N)) begin
      if (hdr_ok) begin
        in_payload_next      = 1'b1;
        held_length_next     = LEN_BITS'(hdr_size);
        bytes_remaining_next = LEN_BITS'(hdr_size);
        held_sender_next     = win_nz[63:32];
        header_window_next   = '0;
        window_fill_next     = '0;
      end else begin
        header_window_next   = win_nz >> BYTE_W;
        window_fill_next     = fill_nz - FILL_W'(1);
      end
    end else begin
      header_window_next = win_nz;
      window_fill_next   = fill_nz;
    end
  end

  // State registers, updated on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      header_window   <= '0;
      window_fill     <= '0;
      in_payload      <= 1'b0;
      bytes_remaining <= '0;
    end else if (s_fire) begin
      header_window   <= header_window_next;
      window_fill     <= window_fill_next;
      in_payload      <= in_payload_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  // Header of the current frame
  always_ff @(posedge clk) begin
    if (rst) begin
      held_length <= '0;
      held_sender <= '0;
    end else if (s_fire) begin
      held_length <= held_length_next;
      held_sender <= held_sender_next;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= in_payload;
    end else if (m_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (s_fire && in_payload) begin
      m_tdata <= {1'b0, FRAME_LEN_W'(held_length), held_sender, s_tdata};
      m_tuser <= (bytes_remaining == held_length);
      m_tlast <= last_byte;
    end
  end

  // Checks
  `RRFD_ASSERT_SAME(a_count_nonzero, in_payload, bytes_remaining != '0,
                    "payload countdown at zero while passing payload")
  `RRFD_ASSERT_SAME(a_count_bound, in_payload, bytes_remaining <= held_length,
                    "payload countdown above frame length")
  `RRFD_ASSERT_SAME(a_fill_hunting, !in_payload, window_fill < FILL_W'(WINDOW_N),
                    "header window full at start of a hunt step")
  `RRFD_ASSERT_NEXT(a_last_ends_frame, s_fire && in_payload && last_byte,
                    !in_payload && window_fill == '0,
                    "frame not closed after its last byte")

endmodule

[bench/resyncing_radio_frame_deframer_test.sv]
`timescale 1ns / 100ps

module resyncing_radio_frame_deframer_test;
  import rrfd_pkg::*;

  localparam int LEN_BITS = LEN_BITS_DEF;
  localparam int MAX_LEN  = (1 << LEN_BITS) - 1;

  // One payload beat as it should leave the m_ side
  typedef struct packed {
    logic [BYTE_W-1:0]      pay;
    logic [SENDER_W-1:0]    sender;
    logic [FRAME_LEN_W-1:0] flen;
    logic                   first;
    logic                   last;
  } payload_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [KEY_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;   // payload_byte, sender_ip, frame_length, zero pad
  logic                  m_tuser;   // first_of_frame
  logic                  m_tlast;   // last_of_frame

  resyncing_radio_frame_deframer #(
    .LEN_BITS (LEN_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  // Stimulus and expectation stores
  logic [BYTE_W-1:0] pending_bytes[$];
  payload_beat_t     expected_beats[$];
  int                bytes_queued = 0;
  int                bytes_taken = 0;
  int                beats_checked = 0;
  int                frames_found = 0;
  int                errors = 0;
  bit                s_sent = 1'b0;

  // Shadow of the deframer state
  logic [KEY_W-1:0]       key_shadow = '0;
  logic [WINDOW_W-1:0]    hunt_window = '0;
  int                     hunt_fill = 0;
  bit                     in_frame = 1'b0;
  int                     frame_left = 0;
  logic [FRAME_LEN_W-1:0] frame_len = '0;
  logic [SENDER_W-1:0]    frame_sender = '0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t MISMATCH %s: got %0h, expected %0h (beat %0d)",
             $realtime, what, got, want, beats_checked);
    errors++;
  endtask

  // Advance the shadow state by one received byte
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    payload_beat_t beat;
    logic [15:0]   sz;
    logic [15:0]   chk;
    if (in_frame) begin
      beat.pay    = b;
      beat.sender = frame_sender;
      beat.flen   = frame_len;
      beat.first  = (frame_left == int'(frame_len));
      beat.last   = (frame_left <= 1);
      expected_beats.push_back(beat);
      if (frame_left <= 1) begin
        in_frame    = 1'b0;
        frame_left  = 0;
        hunt_window = '0;
        hunt_fill   = 0;
      end else begin
        frame_left--;
      end
    end else begin
      if (hunt_fill < WINDOW_N) begin
        hunt_window = hunt_window | (WINDOW_W'(b) << (8 * hunt_fill));
        hunt_fill++;
      end
      // leading zero bytes never open a header
      while (hunt_fill > 0 && hunt_window[7:0] == 8'h00) begin
        hunt_window = hunt_window >> 8;
        hunt_fill--;
      end
      if (hunt_fill == WINDOW_N) begin
        sz  = hunt_window[15:0];
        chk = hunt_window[31:16];
        if (sz == (chk ^ key_shadow) && sz != 16'd0 && !sz[15] && int'(sz) <= MAX_LEN) begin
          in_frame     = 1'b1;
          frame_len    = sz[FRAME_LEN_W-1:0];
          frame_left   = int'(sz);
          frame_sender = hunt_window[63:32];
          hunt_window  = '0;
          hunt_fill    = 0;
          frames_found++;
        end else begin
          hunt_window = hunt_window >> 8;
          hunt_fill--;
        end
      end
    end
  endtask

  // Monitor: key writes, input transactions and output checks
  always @(posedge clk) begin
    payload_beat_t want;
    if (!rst) begin
      if (cfg_we)
        key_shadow = cfg_wdata;
      if (s_tvalid && s_tready) begin
        deframe_byte(s_tdata);
        bytes_taken++;
        s_sent = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("result with no expectation", 64'(m_tdata), 64'd0);
        end else begin
          want = expected_beats.pop_front();
          if (m_tdata[7:0] !== want.pay)
            report_mismatch("payload_byte", 64'(m_tdata[7:0]), 64'(want.pay));
          if (m_tdata[39:8] !== want.sender)
            report_mismatch("sender_ip", 64'(m_tdata[39:8]), 64'(want.sender));
          if (m_tdata[54:40] !== want.flen)
            report_mismatch("frame_length", 64'(m_tdata[54:40]), 64'(want.flen));
          if (m_tdata[55] !== 1'b0)
            report_mismatch("tdata pad", 64'(m_tdata[55]), 64'd0);
          if (m_tuser !== want.first)
            report_mismatch("first_of_frame", 64'(m_tuser), 64'(want.first));
          if (m_tlast !== want.last)
            report_mismatch("last_of_frame", 64'(m_tlast), 64'(want.last));
        end
        beats_checked++;
      end
    end
  end

  // Driver: bursts of bytes with random gaps between them
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_sent) begin
      s_sent = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        s_tdata  <= pending_bytes.pop_front();
        s_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern redrawn at random from four modes
  int stall_mode = 0;
  int stall_tick = 0;

  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0)
      stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      2: m_tready <= (stall_tick % 4 == 0);
      default: m_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_header(input logic [15:0] sz, input logic [15:0] chk,
                              input logic [31:0] ip);
    queue_byte(sz[7:0]);
    queue_byte(sz[15:8]);
    queue_byte(chk[7:0]);
    queue_byte(chk[15:8]);
    for (int i = 0; i < 4; i++)
      queue_byte(ip[8*i +: 8]);
  endtask

  task automatic queue_frame(input int sz, input logic [31:0] ip);
    queue_header(16'(sz), 16'(sz) ^ key_shadow, ip);
    for (int i = 0; i < sz; i++)
      queue_byte(8'($urandom));
  endtask

  // Mixture of good frames, damaged headers and line noise
  task automatic queue_traffic(input int target);
    int start;
    int pick;
    int sz;
    logic [15:0] bad;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        repeat ($urandom_range(0, 3)) queue_byte(8'h00);
        sz = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        queue_frame(sz, $urandom);
      end else if (pick < 80) begin
        case ($urandom_range(0, 2))
          0: begin
            bad = 16'($urandom_range(1, 255));
            queue_header(bad, bad ^ key_shadow ^ 16'($urandom_range(1, 65535)), $urandom);
          end
          1: queue_header(16'h0000, key_shadow, $urandom);
          default: begin
            bad = 16'h8000 | 16'($urandom);
            queue_header(bad, bad ^ key_shadow, $urandom);
          end
        endcase
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 10)) queue_byte(8'($urandom));
      end else begin
        // header cut short
        sz = $urandom_range(1, 24);
        bad = 16'(sz) ^ key_shadow;
        queue_byte(8'(sz));
        queue_byte(8'(sz >> 8));
        if ($urandom_range(0, 1) == 1) queue_byte(bad[7:0]);
        if ($urandom_range(0, 1) == 1) queue_byte(bad[15:8]);
      end
    end
  endtask

  // Wait for all bytes taken and all beats seen, then let the pipeline drain
  task automatic drain;
    while (bytes_taken != bytes_queued) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size_key(input logic [KEY_W-1:0] k);
    @(negedge clk);
    cfg_wdata <= k;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // key zero: shortest frame, extremes, invalid sizes
    write_size_key(16'h0000);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_frame(1, 32'hFFFF_FFFF);
    queue_header(16'h8003, 16'h8003 ^ key_shadow, 32'h0102_0304);
    queue_header(16'h0000, key_shadow, 32'hFF00_00FF);
    queue_traffic(100);
    drain();

    // all-ones key
    write_size_key(16'hFFFF);
    queue_traffic(150);
    drain();

    // random key with one long frame whose size has a non-zero upper byte
    write_size_key(16'($urandom));
    queue_frame(260, $urandom);
    queue_traffic(100);
    drain();

    write_size_key(16'($urandom));
    queue_traffic(150);
    drain();

    foreach (expected_beats[i])
      report_mismatch("expected beat never arrived", 64'd0, 64'(expected_beats[i].pay));

    $display("Run covered %0d received bytes, %0d headers found, %0d payload beats checked",
             bytes_taken, frames_found, beats_checked);
    $display("over four size_key settings including all-zero and all-one keys");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Timeout: run did not finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
